// ===== rtl/kplt_pkg.sv =====
`timescale 1ns / 1ps

package kplt_pkg;

  localparam int KEY_COUNT = 3;
  localparam int KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int CNT_W     = 16;
  localparam int TIME_W    = 32;
  localparam int THR_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LVL = 1'd1;

  localparam logic [THR_W-1:0] THR_RESET = 16'd1000;

  localparam int IN_RAW_W  = KEY_COUNT + TIME_W;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 2 + 2 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef struct packed {
    logic              was_pressed;
    logic [TIME_W-1:0] start_time;
    logic              long_counted;
    logic              long_flag;
    logic [CNT_W-1:0]  press_total;
    logic [CNT_W-1:0]  long_total;
  } key_entry_t;

  typedef struct packed {
    logic is_pressed;
    logic is_long_pressed;
  } key_status_t;

endpackage

// ===== rtl/key_press_long_press_tracker_top.sv =====
`timescale 1ns / 1ps
// Each accepted request is registered, then the sequencer visits keys 0 to KEY_COUNT-1 in order,
// registering one result per key; a new request is taken only once the last key is done.
// One entry is visited per cycle while out_tready does not stall the output register.
// Reset (rst_n low, synchronous): all key state reads as zero via per-entry valid bits,
// threshold 1000 ms, pressed level 0, no result pending.

module key_press_long_press_tracker_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] key_levels, [34:3] now_ms, rest zero
  input  logic [kplt_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] is_pressed, [1] is_long_pressed, [17:2] press_count, [33:18] long_press_count
  output logic [kplt_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [1:0] key_index
  output logic [kplt_pkg::KEY_W-1:0]          out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [kplt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kplt_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  localparam int ENT_W = $bits(kplt_pkg::key_entry_t);
  localparam logic [kplt_pkg::KEY_W-1:0] LAST_KEY = kplt_pkg::KEY_W'(kplt_pkg::KEY_COUNT - 1);

  logic                                state_r, state_nxt;
  logic [kplt_pkg::KEY_W-1:0]          key_r, key_nxt;
  logic [kplt_pkg::KEY_COUNT-1:0]      lev_r;
  logic [kplt_pkg::TIME_W-1:0]         now_r;
  logic [kplt_pkg::THR_W-1:0]          thr_r;
  logic                                plvl_r;

  logic [ENT_W-1:0]                    mem [kplt_pkg::KEY_COUNT];
  logic [kplt_pkg::KEY_COUNT-1:0]      valid_r;
  logic [ENT_W-1:0]                    rd_q_r;
  logic                                rd_vld_r;
  logic [kplt_pkg::KEY_W-1:0]          rd_addr;

  kplt_pkg::key_entry_t                cur_entry;
  kplt_pkg::key_entry_t                new_entry;
  kplt_pkg::key_status_t               status;

  logic                                out_valid_r;
  logic [kplt_pkg::OUT_DATA_W-1:0]     out_data_r;
  logic [kplt_pkg::KEY_W-1:0]          out_user_r;
  logic                                out_last_r;

  logic                                in_acc;
  logic                                adv;
  logic                                last;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign last      = (key_r == LAST_KEY);
  assign adv       = (state_r == S_UPD) && (!out_valid_r || out_tready);
  assign rd_addr   = (adv && !last) ? key_r + 1'b1 : key_r;
  assign cur_entry = rd_vld_r ? kplt_pkg::key_entry_t'(rd_q_r) : '0;

  kplt_key_update u_upd (
    .entry         (cur_entry),
    .level         (lev_r[key_r]),
    .now_ms        (now_r),
    .threshold     (thr_r),
    .pressed_level (plvl_r),
    .entry_nxt     (new_entry),
    .status        (status)
  );

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    case (state_r)
      S_IDLE: begin
        key_nxt = '0;
        if (in_acc) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (adv) begin
          if (last) begin
            state_nxt = S_IDLE;
            key_nxt   = '0;
          end else begin
            key_nxt = key_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        key_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mem[key_r] <= ENT_W'(new_entry);
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_r       <= '0;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      thr_r       <= kplt_pkg::THR_RESET;
      plvl_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      key_r    <= key_nxt;
      rd_vld_r <= valid_r[rd_addr] || (adv && (rd_addr == key_r));
      if (adv) begin
        valid_r[key_r] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          kplt_pkg::CFG_THRESHOLD: thr_r  <= cfg_wdata[kplt_pkg::THR_W-1:0];
          kplt_pkg::CFG_PRESS_LVL: plvl_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lev_r <= in_tdata[kplt_pkg::KEY_COUNT-1:0];
      now_r <= in_tdata[kplt_pkg::IN_RAW_W-1:kplt_pkg::KEY_COUNT];
    end
    if (adv) begin
      out_data_r <= kplt_pkg::OUT_DATA_W'({new_entry.long_total, new_entry.press_total,
                                           status.is_long_pressed, status.is_pressed});
      out_user_r <= key_r;
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  a_acc_starts_key0: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_UPD) && (key_r == '0))
    else $error("request did not start at key 0");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("result not presented after update");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after last key");

  a_tlast_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == LAST_KEY))
    else $error("tlast on a key other than the last");

  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> valid_r[$past(key_r)])
    else $error("written entry not marked valid");

endmodule

// ===== rtl/kplt_key_update.sv =====
`timescale 1ns / 1ps

module kplt_key_update (
  input  kplt_pkg::key_entry_t            entry,
  input  logic                            level,
  input  logic [kplt_pkg::TIME_W-1:0]     now_ms,
  input  logic [kplt_pkg::THR_W-1:0]      threshold,
  input  logic                            pressed_level,
  output kplt_pkg::key_entry_t            entry_nxt,
  output kplt_pkg::key_status_t           status
);

  logic                        pressed;
  logic [kplt_pkg::TIME_W-1:0] start;
  logic [kplt_pkg::TIME_W-1:0] elapsed;
  logic                        lc;

  always_comb begin
    pressed   = (level == pressed_level);
    entry_nxt = entry;
    start     = entry.was_pressed ? entry.start_time : now_ms;
    lc        = entry.was_pressed ? entry.long_counted : 1'b0;
    elapsed   = now_ms - start;
    if (pressed) begin
      if (!entry.was_pressed) begin
        entry_nxt.was_pressed  = 1'b1;
        entry_nxt.start_time   = now_ms;
        entry_nxt.long_counted = 1'b0;
        entry_nxt.press_total  = entry.press_total + 1'b1;
      end
      if (!lc && (elapsed >= kplt_pkg::TIME_W'(threshold))) begin
        entry_nxt.long_counted = 1'b1;
        entry_nxt.long_flag    = 1'b1;
        entry_nxt.long_total   = entry.long_total + 1'b1;
      end
    end else begin
      entry_nxt.was_pressed  = 1'b0;
      entry_nxt.long_counted = 1'b0;
      entry_nxt.long_flag    = 1'b0;
    end
    status.is_pressed      = pressed;
    status.is_long_pressed = entry_nxt.long_flag;
  end

endmodule
